// ----- hw/rtl/edd_pkg.sv -----
`default_nettype none

package edd_pkg;

	// default geometry limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// geometry after reset
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// configuration port
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	// pixel arithmetic
	localparam int           LINE_W        = 9;
	localparam logic [7:0]   PIX_THRESHOLD = 8'd127;
	localparam logic [7:0]   PIX_MAX       = 8'd255;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_CLAMP_MODE   = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [7:0] gray_pixel;
	} pixel_t;

	typedef struct packed {
		logic white_bit;
		logic frame_end;
	} result_t;

	// position of a pixel inside the frame
	typedef struct packed {
		logic first_row;
		logic last_row;
		logic last_col;
	} pos_ctrl_t;

	// last index of a clamped frame dimension
	function automatic int eff_last(input int value, input int limit);
		int r;
		if (value == 0) begin
			r = 0;
		end else if (value > limit) begin
			r = limit - 1;
		end else begin
			r = value - 1;
		end
		return r;
	endfunction

	// product / 16, truncated toward zero
	function automatic logic signed [7:0] spread16(input logic signed [11:0] prod);
		logic signed [11:0] biased;
		biased = prod[11] ? prod + 12'sd15 : prod;
		return 8'(biased >>> 4);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/edd_stream_if.sv -----
`default_nettype none

interface edd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/edd_line_mem.sv -----
`default_nettype none

module edd_line_mem #(
	parameter int DEPTH = edd_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(edd_pkg::DEF_MAX_WIDTH),
	parameter int DW    = edd_pkg::LINE_W
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/edd_diffuse.sv -----
`default_nettype none

module edd_diffuse #(
	parameter int XW = $clog2(edd_pkg::DEF_MAX_WIDTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            restart,
	input  wire logic                            clamp_mode,
	input  wire logic                            valid_s1,
	input  wire logic [7:0]                      gray_s1,
	input  wire logic [XW-1:0]                   x_s1,
	input  wire edd_pkg::pos_ctrl_t              ctrl_s1,
	input  wire logic [edd_pkg::LINE_W-1:0]      rd_data,
	output logic                                 wr_en,
	output logic      [XW-1:0]                   wr_addr,
	output logic      [edd_pkg::LINE_W-1:0]      wr_data,
	output edd_pkg::result_t                     res
);

	// error state
	logic signed [6:0]                  carry_q;
	logic signed [6:0]                  pend_left_q;
	logic signed [3:0]                  pend_here_q;
	logic signed [edd_pkg::LINE_W-1:0]  tail_q;

	// bypass of the write made in the previous cycle
	logic                               fwd_valid_q;
	logic [XW-1:0]                      fwd_addr_q;
	logic [edd_pkg::LINE_W-1:0]         fwd_data_q;

	logic                               fwd_hit;
	logic signed [edd_pkg::LINE_W-1:0]  line_val;
	logic signed [9:0]                  sum;
	logic [7:0]                         adj;
	logic                               white;
	logic signed [8:0]                  e9;
	logic signed [7:0]                  err;
	logic signed [11:0]                 p7, p5, p3, p1;
	logic signed [6:0]                  s7, s5;
	logic signed [5:0]                  s3;
	logic signed [3:0]                  s1w;
	logic signed [6:0]                  pend_left_nx;

	always_comb begin
		fwd_hit = fwd_valid_q && (fwd_addr_q == x_s1);
		if (ctrl_s1.first_row) begin
			line_val = '0;
		end else if (ctrl_s1.last_col) begin
			line_val = tail_q;
		end else if (fwd_hit) begin
			line_val = $signed(fwd_data_q);
		end else begin
			line_val = $signed(rd_data);
		end

		sum = $signed({2'b00, gray_s1}) + 10'(carry_q) + 10'(line_val);

		if (clamp_mode && sum < 10'sd0) begin
			adj = 8'd0;
		end else if (clamp_mode && sum > 10'sd255) begin
			adj = edd_pkg::PIX_MAX;
		end else begin
			adj = sum[7:0];
		end

		white = adj > edd_pkg::PIX_THRESHOLD;
		e9    = $signed({1'b0, adj}) - (white ? $signed({1'b0, edd_pkg::PIX_MAX}) : 9'sd0);
		err   = $signed(e9[7:0]);

		p7  = 12'(err) * 12'sd7;
		p5  = 12'(err) * 12'sd5;
		p3  = 12'(err) * 12'sd3;
		p1  = 12'(err);
		s7  = 7'(edd_pkg::spread16(p7));
		s5  = 7'(edd_pkg::spread16(p5));
		s3  = 6'(edd_pkg::spread16(p3));
		s1w = 4'(edd_pkg::spread16(p1));

		pend_left_nx = 7'(pend_here_q) + s5;

		// below-left neighbor is complete once its 3/16 share is in
		wr_en   = valid_s1 && !ctrl_s1.last_row && (x_s1 != '0);
		wr_addr = x_s1 - XW'(1);
		wr_data = 9'(pend_left_q) + 9'(s3);

		res.white_bit = white;
		res.frame_end = ctrl_s1.last_col && ctrl_s1.last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q     <= '0;
			pend_left_q <= '0;
			pend_here_q <= '0;
			tail_q      <= '0;
			fwd_valid_q <= 1'b0;
		end else if (restart) begin
			carry_q     <= '0;
			pend_left_q <= '0;
			pend_here_q <= '0;
			tail_q      <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			if (valid_s1) begin
				carry_q <= ctrl_s1.last_col ? 7'sd0 : s7;
				if (ctrl_s1.last_row) begin
					pend_left_q <= '0;
					pend_here_q <= '0;
				end else if (ctrl_s1.last_col) begin
					// last column entry lives in a register, not the line
					tail_q      <= 9'(pend_left_nx);
					pend_left_q <= '0;
					pend_here_q <= '0;
				end else begin
					pend_left_q <= pend_left_nx;
					pend_here_q <= s1w;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/edd_out_buf.sv -----
`default_nettype none

module edd_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire edd_pkg::result_t  push_data,
	input  wire logic              pop,
	output logic                   out_valid,
	output edd_pkg::result_t       out_data,
	output logic      [1:0]        count
);

	edd_pkg::result_t slot_q [2];
	logic [1:0]       count_q;

	assign out_valid = count_q != 2'd0;
	assign out_data  = slot_q[0];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				slot_q[0] <= push_data;
			end else begin
				slot_q[0] <= slot_q[1];
			end
			if (push && count_q == 2'd2) begin
				slot_q[1] <= push_data;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				slot_q[0] <= push_data;
			end else begin
				slot_q[1] <= push_data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != 2'd2) || pop)
		else $error("result buffer overflow");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/error_diffusion_dither_1bit_core.sv -----
// 1-bit error-diffusion dither of an 8-bit grayscale stream in raster order.
// pixel channel (sink): one gray_pixel per transaction, valid/ready.
// result channel (source): one white_bit per pixel plus frame_end on the
// last pixel of the frame, valid/ready, strictly in input order.
// config port: cfg_wr_en/cfg_index/cfg_data, written while the block is idle;
// a width or height write restarts the frame, a clamp_mode write does not.
// throughput: one pixel per clock unless pixel ready drops. The error of a
// pixel feeds the next one through the carry register; the row-to-row errors
// sit in a line memory read at accept time and written back in the following
// cycle (one read and one write port), with a bypass for the case where both
// hit one entry. Path: the pixel transaction loads the line read and the
// error stage registers, the next edge puts the result into the result
// buffer, and the result transaction is taken from there.
// stall: a two-entry result buffer keeps the pipe moving; pixel ready drops
// only when that buffer and the error stage would otherwise overflow.
// reset: geometry returns to 640 x 480 (clamped to the maximum), wrap mode,
// counters and carries cleared. The line memory is not cleared: the first
// row of each frame ignores it, so no clearing pass is needed.
`default_nettype none

module error_diffusion_dither_1bit_core #(
	parameter int MAX_WIDTH  = edd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = edd_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	edd_stream_if.sink                              pixel,
	edd_stream_if.source                            result,
	input  wire logic                               cfg_wr_en,
	input  wire logic [edd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [edd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// configuration, held as last column / last row index
	logic [XW-1:0] wlast_q;
	logic [YW-1:0] hlast_q;
	logic          clamp_q;

	// position of the next pixel
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;

	// error stage inputs
	logic               valid_s1;
	logic [7:0]         gray_s1;
	logic [XW-1:0]      x_s1;
	edd_pkg::pos_ctrl_t ctrl_s1;

	logic                          accept;
	logic                          restart;
	edd_pkg::pos_ctrl_t            pos;
	logic [edd_pkg::LINE_W-1:0]    rd_data;
	logic                          wr_en;
	logic [XW-1:0]                 wr_addr;
	logic [edd_pkg::LINE_W-1:0]    wr_data;
	edd_pkg::result_t              res;
	logic                          pop;
	logic [1:0]                    buf_count;

	assign accept  = pixel.valid && pixel.ready;
	assign pop     = result.valid && result.ready;
	assign restart = cfg_wr_en && (edd_pkg::cfg_reg_e'(cfg_index) == edd_pkg::CFG_IMAGE_WIDTH ||
		edd_pkg::cfg_reg_e'(cfg_index) == edd_pkg::CFG_IMAGE_HEIGHT);

	// room for this transaction once the error stage and buffer have settled
	assign pixel.ready = (3'(buf_count) + 3'(valid_s1)) <= (3'd1 + 3'(pop));

	assign pos.first_row = row_q == '0;
	assign pos.last_row  = row_q == hlast_q;
	assign pos.last_col  = col_q == wlast_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= XW'(edd_pkg::eff_last(edd_pkg::RESET_WIDTH, MAX_WIDTH));
			hlast_q <= YW'(edd_pkg::eff_last(edd_pkg::RESET_HEIGHT, MAX_HEIGHT));
			clamp_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (edd_pkg::cfg_reg_e'(cfg_index))
				edd_pkg::CFG_IMAGE_WIDTH: begin
					wlast_q <= XW'(edd_pkg::eff_last(
						int'(cfg_data[edd_pkg::WIDTH_REG_W-1:0]), MAX_WIDTH));
				end
				edd_pkg::CFG_IMAGE_HEIGHT: begin
					hlast_q <= YW'(edd_pkg::eff_last(
						int'(cfg_data[edd_pkg::HEIGHT_REG_W-1:0]), MAX_HEIGHT));
				end
				edd_pkg::CFG_CLAMP_MODE: begin
					clamp_q <= cfg_data[0];
				end
				default: begin
					// unknown index, ignored
				end
			endcase
		end
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + YW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// accept stage: line read issued here, data lands with the s1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= pixel.data.gray_pixel;
			x_s1    <= col_q;
			ctrl_s1 <= pos;
		end
	end

	edd_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW   (XW),
		.DW   (edd_pkg::LINE_W)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	edd_diffuse #(
		.XW(XW)
	) u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.clamp_mode(clamp_q),
		.valid_s1  (valid_s1),
		.gray_s1   (gray_s1),
		.x_s1      (x_s1),
		.ctrl_s1   (ctrl_s1),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res       (res)
	);

	edd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(res),
		.pop      (pop),
		.out_valid(result.valid),
		.out_data (result.data),
		.count    (buf_count)
	);

`ifndef NO_ASSERTIONS
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> col_q <= wlast_q)
		else $error("column counter beyond frame width");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.last_col && pos.last_row |=> col_q == '0 && row_q == '0)
		else $error("counters did not return to origin after frame end");

	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> buf_count != 2'd0)
		else $error("pixel channel stalled with empty result buffer");
`endif

endmodule

`default_nettype wire
